[src/spba_pkg.sv]
package spba_pkg;

  localparam int PoolCount = 4;
  localparam int MaxBlocks = 256;
  localparam int PoolW = 2;
  localparam int BlkW = 8;
  localparam int BytesW = 12;
  localparam int CountW = 9;
  localparam int CfgIdxW = 4;
  localparam int AddrW = PoolW + BlkW;
  localparam int Depth = PoolCount * MaxBlocks;
  localparam int QDepth = 2;

  localparam logic [CountW-1:0] MaxBlocksC = CountW'(MaxBlocks);
  localparam logic [PoolW-1:0] HintReset = PoolW'(PoolCount >> 1);
  localparam logic [PoolW-1:0] LastPool = PoolW'(PoolCount - 1);

  localparam logic OpAlloc = 1'b0;
  localparam logic OpRelease = 1'b1;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrExhausted = 2'd1;
  localparam logic [1:0] ErrRange = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgBytesBase = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgCountBase = CfgIdxW'(4);

  typedef struct packed {
    logic [PoolCount-1:0][BytesW-1:0] bytes;
    logic [PoolCount-1:0][CountW-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic op;
    logic range_err;
    logic [BytesW-1:0] req;
    logic [PoolW-1:0] pool;
    logic [BlkW-1:0] blk;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POOL,
    ST_ISSUE,
    ST_CHECK,
    ST_DONE
  } state_t;

  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] c);
    return (c > MaxBlocksC) ? MaxBlocksC : c;
  endfunction

endpackage

[src/spba_ram.sv]
module spba_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[src/spba_cfg.sv]
module spba_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [spba_pkg::CfgIdxW-1:0]     idx,
  input  logic [spba_pkg::BytesW-1:0]      wdata,
  output spba_pkg::cfg_t                   cfg
);
  spba_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    for (int p = 0; p < spba_pkg::PoolCount; p++) begin
      if (we && idx == spba_pkg::CfgBytesBase + spba_pkg::CfgIdxW'(p)) begin
        cfg_nxt.bytes[p] = wdata;
      end
      if (we && idx == spba_pkg::CfgCountBase + spba_pkg::CfgIdxW'(p)) begin
        cfg_nxt.count[p] = wdata[spba_pkg::CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bytes[0] <= spba_pkg::BytesW'(256);
      cfg_r.bytes[1] <= spba_pkg::BytesW'(64);
      cfg_r.bytes[2] <= spba_pkg::BytesW'(32);
      cfg_r.bytes[3] <= spba_pkg::BytesW'(16);
      for (int p = 0; p < spba_pkg::PoolCount; p++) begin
        cfg_r.count[p] <= spba_pkg::MaxBlocksC;
      end
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;
endmodule

[src/spba_front.sv]
module spba_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spba_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [spba_pkg::BytesW-1:0]   in_request_bytes,
  input  logic [spba_pkg::PoolW-1:0]    in_release_pool,
  input  logic [spba_pkg::BlkW-1:0]     in_release_block,
  output logic                          q_valid,
  output spba_pkg::item_t               q_item,
  input  logic                          q_pop
);
  spba_pkg::item_t q_r [spba_pkg::QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  spba_pkg::item_t item_c;
  logic push;

  always_comb begin
    item_c.op = in_operation;
    item_c.req = in_request_bytes;
    item_c.pool = in_release_pool;
    item_c.blk = in_release_block;
    item_c.range_err = ({1'b0, in_release_block} >=
                        spba_pkg::eff_count(cfg.count[in_release_pool]));
  end

  assign in_ready = (cnt_r < 2'(spba_pkg::QDepth));
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item = q_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = (q_pop && q_valid) ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item_c;
    end
  end
endmodule

[src/spba_back.sv]
module spba_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spba_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  input  spba_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_granted,
  output logic [1:0]                    out_error_code,
  output logic [spba_pkg::PoolW-1:0]    out_pool_index,
  output logic [spba_pkg::BlkW-1:0]     out_block_index
);
  localparam logic SideR = 1'b0;
  localparam logic SideL = 1'b1;

  spba_pkg::state_t state_r, state_nxt;
  spba_pkg::item_t item_r, item_nxt;
  logic [2:0] pnext_r, pnext_nxt;
  logic [spba_pkg::PoolW-1:0] pool_r, pool_nxt, hint_r, hint_nxt;
  logic signed [9:0] r_r, e_r, l_r, s_r, r_nxt, e_nxt, l_nxt, s_nxt;
  logic side_r, side_nxt, half_r, half_nxt, sel_r, sel_nxt;
  logic [spba_pkg::BlkW-1:0] cand_r, cand_nxt;
  logic [spba_pkg::AddrW-1:0] clr_r, clr_nxt;
  logic [spba_pkg::BlkW-1:0] last_r [spba_pkg::PoolCount];
  logic [spba_pkg::BlkW-1:0] last_nxt [spba_pkg::PoolCount];
  logic res_g_r, res_g_nxt;
  logic [1:0] res_e_r, res_e_nxt;
  logic [spba_pkg::PoolW-1:0] res_p_r, res_p_nxt;
  logic [spba_pkg::BlkW-1:0] res_b_r, res_b_nxt;
  logic ov_r, ov_nxt, og_r, og_nxt;
  logic [1:0] oe_r, oe_nxt;
  logic [spba_pkg::PoolW-1:0] op_r, op_nxt;
  logic [spba_pkg::BlkW-1:0] ob_r, ob_nxt;

  logic ram_we, ram_wd, ram_rd;
  logic [spba_pkg::AddrW-1:0] ram_wa, ram_ra;

  logic [spba_pkg::PoolW-1:0] p_c;
  logic [spba_pkg::CountW-1:0] n_c;
  logic [spba_pkg::BlkW-1:0] last_c;
  logic fits_c, av_r, av_l, fail_c, sel_c, slot_free;

  spba_ram #(.Width(1), .Depth(spba_pkg::Depth)) u_used (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign p_c = pnext_r[spba_pkg::PoolW-1:0] - spba_pkg::PoolW'(1);
  assign n_c = spba_pkg::eff_count(cfg.count[p_c]);
  assign last_c = ({1'b0, last_r[p_c]} >= n_c) ? spba_pkg::BlkW'(n_c - 9'd1) : last_r[p_c];
  assign fits_c = (item_r.req <= cfg.bytes[p_c]) && (n_c != '0);
  assign av_r = (r_r <= e_r);
  assign av_l = (l_r >= s_r);
  assign slot_free = !ov_r || out_ready;

  always_comb begin
    fail_c = 1'b0;
    sel_c = sel_r;
    if (!half_r) begin
      if (side_r == SideR) begin
        sel_c = av_r ? SideR : SideL;
        fail_c = !av_r && !av_l;
      end else begin
        sel_c = av_l ? SideL : SideR;
        fail_c = !av_r && !av_l;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      spba_pkg::ST_CLEAR: if (clr_r == '1) state_nxt = spba_pkg::ST_IDLE;
      spba_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_item.op == spba_pkg::OpRelease) ? spba_pkg::ST_DONE : spba_pkg::ST_POOL;
        end
      end
      spba_pkg::ST_POOL: begin
        if (pnext_r == 3'd0) state_nxt = spba_pkg::ST_DONE;
        else if (fits_c) state_nxt = spba_pkg::ST_ISSUE;
      end
      spba_pkg::ST_ISSUE: state_nxt = fail_c ? spba_pkg::ST_POOL : spba_pkg::ST_CHECK;
      spba_pkg::ST_CHECK: state_nxt = ram_rd ? spba_pkg::ST_ISSUE : spba_pkg::ST_DONE;
      spba_pkg::ST_DONE: if (slot_free) state_nxt = spba_pkg::ST_IDLE;
      default: state_nxt = spba_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    item_nxt = item_r; pnext_nxt = pnext_r; pool_nxt = pool_r; hint_nxt = hint_r;
    r_nxt = r_r; e_nxt = e_r; l_nxt = l_r; s_nxt = s_r;
    side_nxt = side_r; half_nxt = half_r; sel_nxt = sel_r; cand_nxt = cand_r;
    clr_nxt = clr_r; last_nxt = last_r;
    res_g_nxt = res_g_r; res_e_nxt = res_e_r; res_p_nxt = res_p_r; res_b_nxt = res_b_r;
    ov_nxt = ov_r && !out_ready; og_nxt = og_r; oe_nxt = oe_r; op_nxt = op_r; ob_nxt = ob_r;
    q_pop = 1'b0;
    ram_we = 1'b0; ram_wd = 1'b0; ram_wa = clr_r;
    ram_ra = {pool_r, cand_r};
    unique case (state_r)
      spba_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        clr_nxt = clr_r + spba_pkg::AddrW'(1);
      end
      spba_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          item_nxt = q_item;
          res_g_nxt = 1'b0; res_e_nxt = spba_pkg::ErrNone; res_p_nxt = '0; res_b_nxt = '0;
          if (q_item.op == spba_pkg::OpRelease) begin
            if (q_item.range_err) begin
              res_e_nxt = spba_pkg::ErrRange;
            end else begin
              ram_we = 1'b1;
              ram_wa = {q_item.pool, q_item.blk};
              last_nxt[q_item.pool] = q_item.blk;
              res_g_nxt = 1'b1; res_p_nxt = q_item.pool; res_b_nxt = q_item.blk;
            end
          end else begin
            pnext_nxt = (cfg.bytes[hint_r] > q_item.req) ? 3'(spba_pkg::PoolCount)
                                                          : {1'b0, hint_r} + 3'd1;
          end
        end
      end
      spba_pkg::ST_POOL: begin
        if (pnext_r == 3'd0) begin
          hint_nxt = spba_pkg::LastPool;
          res_e_nxt = spba_pkg::ErrExhausted;
        end else begin
          pnext_nxt = {1'b0, p_c};
          pool_nxt = p_c;
          r_nxt = 10'(last_c) + 10'sd1;
          e_nxt = 10'(n_c) - 10'sd1;
          l_nxt = 10'(last_c);
          s_nxt = '0;
          side_nxt = SideR; half_nxt = 1'b0;
        end
      end
      spba_pkg::ST_ISSUE: begin
        sel_nxt = sel_c;
        if (sel_c == SideR) cand_nxt = half_r ? e_r[7:0] : r_r[7:0];
        else cand_nxt = half_r ? s_r[7:0] : l_r[7:0];
        ram_ra = {pool_r, cand_nxt};
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          side_nxt = ~sel_r;
          if (sel_r == SideR) begin
            r_nxt = r_r + 10'sd1; e_nxt = e_r - 10'sd1;
          end else begin
            l_nxt = l_r - 10'sd1; s_nxt = s_r + 10'sd1;
          end
        end
      end
      spba_pkg::ST_CHECK: begin
        if (!ram_rd) begin
          ram_we = 1'b1; ram_wd = 1'b1; ram_wa = {pool_r, cand_r};
          last_nxt[pool_r] = cand_r;
          hint_nxt = pool_r;
          res_g_nxt = 1'b1; res_p_nxt = pool_r; res_b_nxt = cand_r;
        end
      end
      spba_pkg::ST_DONE: begin
        if (slot_free) begin
          ov_nxt = 1'b1; og_nxt = res_g_r; oe_nxt = res_e_r; op_nxt = res_p_r; ob_nxt = res_b_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spba_pkg::ST_CLEAR;
      clr_r <= '0;
      hint_r <= spba_pkg::HintReset;
      ov_r <= 1'b0;
      for (int p = 0; p < spba_pkg::PoolCount; p++) last_r[p] <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      hint_r <= hint_nxt;
      ov_r <= ov_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt; pnext_r <= pnext_nxt; pool_r <= pool_nxt;
    r_r <= r_nxt; e_r <= e_nxt; l_r <= l_nxt; s_r <= s_nxt;
    side_r <= side_nxt; half_r <= half_nxt; sel_r <= sel_nxt; cand_r <= cand_nxt;
    res_g_r <= res_g_nxt; res_e_r <= res_e_nxt; res_p_r <= res_p_nxt; res_b_r <= res_b_nxt;
    og_r <= og_nxt; oe_r <= oe_nxt; op_r <= op_nxt; ob_r <= ob_nxt;
  end

  assign out_valid = ov_r;
  assign out_granted = og_r;
  assign out_error_code = oe_r;
  assign out_pool_index = op_r;
  assign out_block_index = ob_r;

  a_grant_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && og_r |-> oe_r == spba_pkg::ErrNone) else $error("granted with error");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spba_pkg::ST_CLEAR |-> !q_pop) else $error("pop during clear");
  a_check_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == spba_pkg::ST_CHECK |-> $past(state_r) == spba_pkg::ST_ISSUE)
    else $error("check without issue");
endmodule

[src/segregated_pool_block_allocator.sv]
// segregated pool block allocator: four pools of fixed-size blocks, pool 0 largest
// input channel (in_valid/in_ready): one transaction is an allocate (operation 0,
// request_bytes) or a release (operation 1, release_pool, release_block)
// output channel (out_valid/out_ready): one result transaction per input transaction,
// in order: granted, error_code, pool_index, block_index
// cfg_we/cfg_index/cfg_wdata: block sizes (index 0..3) and counts (4..7), write when idle
// one transaction is served at a time; a release goes from the queue through the done
// state to the output register; an allocate passes a pool state for each pool visited,
// an issue and a check state for each block mark examined, and a further pool state for
// each fitting pool found full; the scan reads the used-mark memory one mark at a time
// reset: a clearing pass writes all 1024 used marks to free, during which up to two
// transactions are queued but none is served
// a stalled receiver holds the result register; the front queue keeps accepting
// until its two entries are full
module segregated_pool_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spba_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [spba_pkg::BytesW-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_operation,
  input  logic [spba_pkg::BytesW-1:0]   in_request_bytes,
  input  logic [spba_pkg::PoolW-1:0]    in_release_pool,
  input  logic [spba_pkg::BlkW-1:0]     in_release_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_granted,
  output logic [1:0]                    out_error_code,
  output logic [spba_pkg::PoolW-1:0]    out_pool_index,
  output logic [spba_pkg::BlkW-1:0]     out_block_index
);
  spba_pkg::cfg_t cfg;
  spba_pkg::item_t q_item;
  logic q_valid, q_pop;

  spba_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .we(cfg_we), .idx(cfg_index), .wdata(cfg_wdata), .cfg(cfg)
  );

  spba_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_request_bytes(in_request_bytes), .in_release_pool(in_release_pool),
    .in_release_block(in_release_block),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  spba_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_granted(out_granted),
    .out_error_code(out_error_code), .out_pool_index(out_pool_index),
    .out_block_index(out_block_index)
  );
endmodule
